>>> hdl/bgl_pkg.sv
// types, constants and helpers for the button gesture / led mode block
// no dependencies; imported by every other file of the block but bgl_if.sv
package bgl_pkg;

   localparam int TIME_BITS = 16;
   localparam int CFG_BITS  = 16;
   localparam int CMP_BITS  = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RST     = 16'd60;
   localparam logic [CFG_BITS-1:0] LONG_PRESS_RST   = 16'd2000;
   localparam logic [CFG_BITS-1:0] DOUBLE_WIN_RST   = 16'd400;
   localparam logic [CFG_BITS-1:0] LOCKOUT_RST      = 16'd100;
   localparam logic [CFG_BITS-1:0] PANIC_RESET_RST  = 16'd3000;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_IDLE  = 2'd1,
      OP_PANIC = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      PH_WAIT   = 2'd0,
      PH_HOLD   = 2'd1,
      PH_WINDOW = 2'd2,
      PH_LOCK   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_SLOW    = 3'd1,
      MODE_FAST    = 3'd2,
      MODE_BREATHE = 3'd3,
      MODE_PANIC   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_SHORT  = 2'd0,
      KIND_DOUBLE = 2'd1,
      KIND_LONG   = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEBOUNCE    = 3'd0,
      CSR_LONG_PRESS  = 3'd1,
      CSR_DOUBLE_WIN  = 3'd2,
      CSR_LOCKOUT     = 3'd3,
      CSR_PANIC_RESET = 3'd4
   } csr_index_type;

   // saturating millisecond counter step
   function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] t);
      return (t == {TIME_BITS{1'b1}}) ? t : t + TIME_BITS'(1);
   endfunction

   function automatic logic [CMP_BITS-1:0] tm_ext(input logic [TIME_BITS-1:0] t);
      return CMP_BITS'(t);
   endfunction

   function automatic logic [CMP_BITS-1:0] cfg_ext(input logic [CFG_BITS-1:0] c);
      return CMP_BITS'(c);
   endfunction

endpackage

>>> hdl/bgl_if.sv
// request and response channel interfaces of the button gesture block
// valid/ready handshake with the payload fields; no dependencies
interface bgl_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic       button_level;

   modport source (output valid, output op, output button_level, input ready);
   modport sink   (input valid, input op, input button_level, output ready);
endinterface

interface bgl_rsp_if;
   logic       valid;
   logic       ready;
   logic       event_valid;
   logic [1:0] event_kind;
   logic [2:0] led_mode;
   logic       reset_request;

   modport source (output valid, output event_valid, output event_kind,
                   output led_mode, output reset_request, input ready);
   modport sink   (input valid, input event_valid, input event_kind,
                   input led_mode, input reset_request, output ready);
endinterface

>>> hdl/button_gesture_led_mode_fsm.sv
// Button gesture detector stepping an led mode state machine.
// Depends on bgl_pkg and the channel interfaces in bgl_if.sv.
//
// req channel: one request per 1 ms tick (op tick with the active-low button
// level) or a force-idle / force-panic command. rsp channel: one response per
// request with the classified press event (if any), the led mode after the
// request and the panic reset request level.
// csr port: csr_we / csr_index / csr_wdata write the five timing thresholds;
// the user must write them only while no request is in flight; the block does not enforce it.
//
// The response of a request accepted at one edge is registered and valid after
// that edge. One request per cycle is taken while the receiver keeps up; all
// work is a single pass of compare/increment logic into the response register.
// req.ready is high while the response register is empty or being taken, so
// a stalled receiver holds the current response and stops further requests
// until it takes it.
// Reset (synchronous) returns thresholds to defaults, the press machine to
// waiting, the led mode to idle and empties the response register.
module button_gesture_led_mode_fsm (
   input  logic                                clock,
   input  logic                                reset,
   bgl_req_if.sink                             req,
   bgl_rsp_if.source                           rsp,
   input  logic                                csr_we,
   input  logic [bgl_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bgl_pkg::CFG_BITS-1:0]        csr_wdata
);
   import bgl_pkg::*;

   logic [CFG_BITS-1:0] debounce_ff, long_press_ff, double_win_ff, lockout_ff, panic_reset_ff;

   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] timer_ff, timer_in;
   logic [TIME_BITS-1:0] since_ff, since_in;
   logic [TIME_BITS-1:0] panic_tmr_ff, panic_tmr_in;
   logic                 pend_ff, pend_in;
   logic                 prev_ff, prev_in;
   mode_type             mode_ff, mode_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 ev_ff, ev_in;
   kind_type             kind_ff, kind_in;
   mode_type             led_ff;
   logic                 rreq_ff, rreq_in;

   logic                 accept;
   logic [TIME_BITS-1:0] t_step;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= DEBOUNCE_RST;
         long_press_ff  <= LONG_PRESS_RST;
         double_win_ff  <= DOUBLE_WIN_RST;
         lockout_ff     <= LOCKOUT_RST;
         panic_reset_ff <= PANIC_RESET_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:    debounce_ff    <= csr_wdata;
            CSR_LONG_PRESS:  long_press_ff  <= csr_wdata;
            CSR_DOUBLE_WIN:  double_win_ff  <= csr_wdata;
            CSR_LOCKOUT:     lockout_ff     <= csr_wdata;
            CSR_PANIC_RESET: panic_reset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         timer_ff     <= '0;
         since_ff     <= '0;
         panic_tmr_ff <= '0;
         pend_ff      <= 1'b0;
         prev_ff      <= 1'b1;
         mode_ff      <= MODE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         since_ff     <= since_in;
         panic_tmr_ff <= panic_tmr_in;
         pend_ff      <= pend_in;
         prev_ff      <= prev_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         ev_ff   <= ev_in;
         kind_ff <= kind_in;
         led_ff  <= mode_in;
         rreq_ff <= rreq_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      timer_in     = timer_ff;
      since_in     = since_ff;
      panic_tmr_in = panic_tmr_ff;
      pend_in      = pend_ff;
      prev_in      = prev_ff;
      mode_in      = mode_ff;
      ev_in        = 1'b0;
      kind_in      = KIND_SHORT;
      t_step       = sat_inc(timer_ff);
      rsp_valid_in = accept ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

      if (accept) begin
         case (op_type'(req.op))
            OP_IDLE: begin
               mode_in      = MODE_IDLE;
               panic_tmr_in = '0;
            end
            OP_PANIC: begin
               mode_in = MODE_PANIC;
            end
            OP_TICK: begin
               since_in = sat_inc(since_ff);
               // debounced falling edge
               if (prev_ff && !req.button_level) begin
                  if (tm_ext(since_in) > cfg_ext(debounce_ff)) pend_in = 1'b1;
                  since_in = '0;
               end
               prev_in = req.button_level;

               case (phase_ff)
                  PH_WAIT: begin
                     if (pend_in) begin
                        pend_in  = 1'b0;
                        phase_in = PH_HOLD;
                        timer_in = '0;
                     end
                  end
                  PH_HOLD: begin
                     timer_in = t_step;
                     if (req.button_level) begin
                        if (tm_ext(t_step) > cfg_ext(long_press_ff)) begin
                           ev_in   = 1'b1;
                           kind_in = KIND_LONG;
                        end else begin
                           phase_in = PH_WINDOW;
                           timer_in = '0;
                        end
                     end
                  end
                  PH_WINDOW: begin
                     if (tm_ext(timer_ff) >= cfg_ext(double_win_ff)) begin
                        ev_in   = 1'b1;
                        kind_in = KIND_SHORT;
                     end else if (!req.button_level) begin
                        ev_in   = 1'b1;
                        kind_in = KIND_DOUBLE;
                     end else begin
                        timer_in = t_step;
                     end
                  end
                  PH_LOCK: begin
                     if (tm_ext(t_step) >= cfg_ext(lockout_ff)) begin
                        phase_in = PH_WAIT;
                        timer_in = '0;
                     end else begin
                        timer_in = t_step;
                     end
                  end
                  default: begin
                     phase_in = PH_WAIT;
                     timer_in = '0;
                  end
               endcase

               if (ev_in) begin
                  pend_in  = 1'b0;
                  phase_in = PH_LOCK;
                  timer_in = '0;
                  case (kind_in)
                     KIND_DOUBLE: mode_in = MODE_IDLE;
                     KIND_LONG:   mode_in = MODE_PANIC;
                     default: begin
                        // short press cycles the four normal modes, ignored in panic
                        case (mode_ff)
                           MODE_IDLE:    mode_in = MODE_SLOW;
                           MODE_SLOW:    mode_in = MODE_FAST;
                           MODE_FAST:    mode_in = MODE_BREATHE;
                           MODE_BREATHE: mode_in = MODE_IDLE;
                           default:      mode_in = mode_ff;
                        endcase
                     end
                  endcase
               end

               panic_tmr_in = (mode_in == MODE_PANIC) ? sat_inc(panic_tmr_ff) : '0;
            end
            default: ;
         endcase
      end

      rreq_in = (mode_in == MODE_PANIC) &&
                (tm_ext(panic_tmr_in) > cfg_ext(panic_reset_ff));
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.event_valid   = ev_ff;
   assign rsp.event_kind    = kind_ff;
   assign rsp.led_mode      = led_ff;
   assign rsp.reset_request = rreq_ff;

endmodule

>>> hdl/bgl_checker.sv
// port-level assertions for button_gesture_led_mode_fsm, attached by bind
// depends on bgl_pkg
module bgl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       event_valid,
   input logic [1:0] event_kind,
   input logic [2:0] led_mode,
   input logic       reset_request
);
   import bgl_pkg::*;

   // every accepted request yields a response on the next cycle
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no response");

   a_kind_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !event_valid) |-> (event_kind == KIND_SHORT))
      else $error("event kind set without an event");

   a_rreq_panic: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && reset_request) |-> (led_mode == MODE_PANIC))
      else $error("reset request outside panic");

   a_long_panic: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && event_valid && event_kind == KIND_LONG) |-> (led_mode == MODE_PANIC))
      else $error("long press did not enter panic");

   // stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(event_valid) &&
         $stable(event_kind) && $stable(led_mode) && $stable(reset_request)))
      else $error("stalled response changed");

endmodule

bind button_gesture_led_mode_fsm bgl_checker u_bgl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .event_valid   (rsp.event_valid),
   .event_kind    (rsp.event_kind),
   .led_mode      (rsp.led_mode),
   .reset_request (rsp.reset_request)
);

>>> tb/sv/gesture_check_pkg.sv
`timescale 1ns / 100ps
// response predictor and checker for the button gesture / led mode block
// depends on bgl_pkg for the codes, widths and threshold defaults
package gesture_check_pkg;
   import bgl_pkg::*;

   typedef struct packed {
      logic       event_valid;
      kind_type   event_kind;
      mode_type   led_mode;
      logic       reset_request;
   } gesture_rsp_type;

   class gesture_checker;
      logic [CFG_BITS-1:0]  debounce_ms;
      logic [CFG_BITS-1:0]  long_press_ms;
      logic [CFG_BITS-1:0]  double_window_ms;
      logic [CFG_BITS-1:0]  lockout_ms;
      logic [CFG_BITS-1:0]  panic_reset_ms;
      phase_type            phase;
      logic [TIME_BITS-1:0] phase_ms;
      logic [TIME_BITS-1:0] since_edge_ms;
      logic [TIME_BITS-1:0] panic_ms;
      logic                 press_waiting;
      logic                 last_level;
      mode_type             mode;
      gesture_rsp_type      expected_rsps[$];
      int unsigned          rsp_count;
      int unsigned          errors;

      function new();
         debounce_ms      = DEBOUNCE_RST;
         long_press_ms    = LONG_PRESS_RST;
         double_window_ms = DOUBLE_WIN_RST;
         lockout_ms       = LOCKOUT_RST;
         panic_reset_ms   = PANIC_RESET_RST;
         phase            = PH_WAIT;
         phase_ms         = '0;
         since_edge_ms    = '0;
         panic_ms         = '0;
         press_waiting    = 1'b0;
         last_level       = 1'b1;
         mode             = MODE_IDLE;
         rsp_count        = 0;
         errors           = 0;
      endfunction

      function logic [TIME_BITS-1:0] ms_up(input logic [TIME_BITS-1:0] t);
         return (&t) ? t : t + TIME_BITS'(1);
      endfunction

      function void set_threshold(input logic [CSR_IDX_BITS-1:0] idx,
                                  input logic [CFG_BITS-1:0] val);
         case (idx)
            CSR_DEBOUNCE:    debounce_ms      = val;
            CSR_LONG_PRESS:  long_press_ms    = val;
            CSR_DOUBLE_WIN:  double_window_ms = val;
            CSR_LOCKOUT:     lockout_ms       = val;
            CSR_PANIC_RESET: panic_reset_ms   = val;
            default: ;
         endcase
      endfunction

      function void step_mode(input kind_type kind);
         if (kind == KIND_DOUBLE) begin
            mode = MODE_IDLE;
         end else if (kind == KIND_LONG) begin
            mode = MODE_PANIC;
         end else begin
            case (mode)
               MODE_IDLE:    mode = MODE_SLOW;
               MODE_SLOW:    mode = MODE_FAST;
               MODE_FAST:    mode = MODE_BREATHE;
               MODE_BREATHE: mode = MODE_IDLE;
               default: ; // short press leaves panic alone
            endcase
         end
      endfunction

      // advance the gesture state by one accepted request, queue its response
      function void note_request(input logic [1:0] op, input logic level);
         gesture_rsp_type r;
         logic            fired;
         kind_type        kind;
         fired = 1'b0;
         kind  = KIND_SHORT;
         if (op == OP_IDLE) begin
            mode     = MODE_IDLE;
            panic_ms = '0;
         end else if (op == OP_PANIC) begin
            mode = MODE_PANIC;
         end else if (op == OP_TICK) begin
            since_edge_ms = ms_up(since_edge_ms);
            if (last_level && !level) begin
               if (since_edge_ms > debounce_ms) press_waiting = 1'b1;
               since_edge_ms = '0;
            end
            last_level = level;
            case (phase)
               PH_WAIT: begin
                  if (press_waiting) begin
                     press_waiting = 1'b0;
                     phase         = PH_HOLD;
                     phase_ms      = '0;
                  end
               end
               PH_HOLD: begin
                  phase_ms = ms_up(phase_ms);
                  if (level) begin
                     if (phase_ms > long_press_ms) begin
                        fired = 1'b1;
                        kind  = KIND_LONG;
                     end else begin
                        phase    = PH_WINDOW;
                        phase_ms = '0;
                     end
                  end
               end
               PH_WINDOW: begin
                  if (phase_ms >= double_window_ms) begin
                     fired = 1'b1;
                     kind  = KIND_SHORT;
                  end else if (!level) begin
                     fired = 1'b1;
                     kind  = KIND_DOUBLE;
                  end else begin
                     phase_ms = ms_up(phase_ms);
                  end
               end
               default: begin
                  phase_ms = ms_up(phase_ms);
                  if (phase_ms >= lockout_ms) begin
                     phase    = PH_WAIT;
                     phase_ms = '0;
                  end
               end
            endcase
            if (fired) begin
               press_waiting = 1'b0;
               phase         = PH_LOCK;
               phase_ms      = '0;
               step_mode(kind);
            end
            if (mode == MODE_PANIC) panic_ms = ms_up(panic_ms);
            else panic_ms = '0;
         end
         r.event_valid   = fired;
         r.event_kind    = fired ? kind : KIND_SHORT;
         r.led_mode      = mode;
         r.reset_request = (mode == MODE_PANIC) && (panic_ms > panic_reset_ms);
         expected_rsps.push_back(r);
      endfunction

      task report(input string what);
         $display("mismatch at response %0d: %s", rsp_count, what);
         errors++;
      endtask

      task check_response(input logic ev, input logic [1:0] kind,
                          input logic [2:0] led, input logic rr);
         gesture_rsp_type e;
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         e = expected_rsps.pop_front();
         if (ev !== e.event_valid)
            report($sformatf("event_valid %b, expected %b", ev, e.event_valid));
         if (kind !== e.event_kind)
            report($sformatf("event_kind %0d, expected %0d", kind, e.event_kind));
         if (led !== e.led_mode)
            report($sformatf("led_mode %0d, expected %0d", led, e.led_mode));
         if (rr !== e.reset_request)
            report($sformatf("reset_request %b, expected %b", rr, e.reset_request));
      endtask
   endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// testbench top for button_gesture_led_mode_fsm: drives requests and threshold
// writes, checks every response; depends on bgl_pkg, bgl_if.sv, gesture_check_pkg
module tb_top;
   import bgl_pkg::*;
   import gesture_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 3'd5;
   localparam logic [CFG_BITS-1:0] CFG_MAX = '1;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;
   logic                    no_idle = 1'b0;
   int unsigned             cycles = 0;
   gesture_checker          scoreboard;

   bgl_req_if req_ch();
   bgl_rsp_if rsp_ch();

   button_gesture_led_mode_fsm u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // mostly no gap, sometimes a short one, rarely a long one
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         scoreboard.check_response(rsp_ch.event_valid, rsp_ch.event_kind,
                                   rsp_ch.led_mode, rsp_ch.reset_request);
   end

   task automatic send_request(input logic [1:0] op, input logic level);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.button_level <= level;
      do @(posedge clock); while (!req_ch.ready);
      scoreboard.note_request(op, level);
   endtask

   // hold off until every response is back, then leave the block idle before going on
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (scoreboard.expected_rsps.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      scoreboard.set_threshold(idx, val);
   endtask

   task automatic write_thresholds(input logic [CFG_BITS-1:0] deb, lng, win, lck, pnc);
      logic [CSR_IDX_BITS-1:0] spare;
      drain();
      spare = CSR_SPARE + CSR_IDX_BITS'($urandom_range(0, 2));
      if ($urandom_range(0, 1)) csr_write(spare, CFG_BITS'($urandom));
      csr_write(CSR_DEBOUNCE, deb);
      csr_write(CSR_LONG_PRESS, lng);
      csr_write(CSR_DOUBLE_WIN, win);
      csr_write(CSR_LOCKOUT, lck);
      csr_write(CSR_PANIC_RESET, pnc);
      csr_we <= 1'b0;
   endtask

   // one stray request; returns 0 for the unused op, which the block answers without a change of state
   task automatic send_noise(output int counted);
      int r;
      r = $urandom_range(0, 19);
      counted = 1;
      if (r < 2) begin
         send_request(OP_IDLE, 1'($urandom));
      end else if (r < 4) begin
         send_request(OP_PANIC, 1'($urandom));
      end else if (r < 5) begin
         send_request(OP_UNUSED, 1'($urandom));
         counted = 0;
      end else begin
         send_request(OP_TICK, 1'($urandom));
      end
   endtask

   // presses of random hold and release lengths around the current thresholds, mixed with stray requests
   task automatic run_gestures(input int count, input logic [CFG_BITS-1:0] lng, win, lck);
      int sent, hold, rest, hold_cap, rest_cap, counted;
      hold_cap = (lng > 36) ? 40 : int'(lng) + 4;
      rest_cap = (int'(win) + int'(lck) > 44) ? 50 : int'(win) + int'(lck) + 6;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
         if ($urandom_range(0, 3) == 0) begin
            send_noise(counted);
            sent += counted;
         end else begin
            hold = $urandom_range(1, hold_cap);
            rest = $urandom_range(1, rest_cap);
            repeat (hold) send_request(OP_TICK, 1'b0);
            repeat (rest) send_request(OP_TICK, 1'b1);
            sent += hold + rest;
         end
      end
   endtask

   initial begin
      logic [CFG_BITS-1:0] deb, lng, win, lck, pnc;
      scoreboard           = new();
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_DEBOUNCE;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.op           <= OP_TICK;
      req_ch.button_level <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // a few requests at the reset thresholds
      run_gestures(12, LONG_PRESS_RST, DOUBLE_WIN_RST, LOCKOUT_RST);

      write_thresholds(16'd0, 16'd3, 16'd2, 16'd0, 16'd2);
      send_request(OP_TICK, 1'b1);
      // short press: slow blink once the window runs out
      send_request(OP_TICK, 1'b0);
      repeat (5) send_request(OP_TICK, 1'b1);
      // double press back to idle
      send_request(OP_TICK, 1'b0);
      send_request(OP_TICK, 1'b1);
      send_request(OP_TICK, 1'b0);
      send_request(OP_TICK, 1'b1);
      // long press into panic, then reset request while panic lasts
      repeat (5) send_request(OP_TICK, 1'b0);
      repeat (3) send_request(OP_TICK, 1'b1);
      // short press while in panic is ignored
      send_request(OP_TICK, 1'b0);
      repeat (4) send_request(OP_TICK, 1'b1);
      send_request(OP_PANIC, 1'b0);
      send_request(OP_UNUSED, 1'b0);
      send_request(OP_IDLE, 1'b1);

      write_thresholds('0, '0, '0, '0, '0);
      run_gestures(150, '0, '0, '0);

      write_thresholds(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
      run_gestures(60, CFG_MAX, CFG_MAX, CFG_MAX);

      repeat (5) begin
         deb = CFG_BITS'($urandom_range(0, 4));
         lng = CFG_BITS'($urandom_range(0, 12));
         win = CFG_BITS'($urandom_range(0, 8));
         lck = CFG_BITS'($urandom_range(0, 6));
         pnc = CFG_BITS'($urandom_range(0, 40));
         write_thresholds(deb, lng, win, lck, pnc);
         run_gestures(200, lng, win, lck);
      end

      deb = CFG_BITS'($urandom_range(0, 20));
      lng = CFG_BITS'($urandom_range(0, 30));
      win = CFG_BITS'($urandom_range(0, 20));
      lck = CFG_BITS'($urandom_range(0, 20));
      pnc = CFG_BITS'($urandom_range(0, 200));
      write_thresholds(deb, lng, win, lck, pnc);
      run_gestures(120, lng, win, lck);

      req_ch.valid <= 1'b0;
      while (scoreboard.expected_rsps.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (scoreboard.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/bgl_pkg.sv
hdl/bgl_if.sv
hdl/button_gesture_led_mode_fsm.sv
hdl/bgl_checker.sv
tb/sv/gesture_check_pkg.sv
tb/sv/tb_top.sv
